@@ rtl/core/jse_pkg.sv @@
// ----------------------------------------------------------------------------
// jse_pkg
// Shared types, character constants and helpers for the JSON string escaper.
// ----------------------------------------------------------------------------
package jse_pkg;

  // Source request: one raw byte with string marks
  typedef struct packed {
    logic [7:0] in_byte;
    logic       first_byte;
    logic       last_byte;
  } in_req_t;

  // Result request: one byte of JSON text
  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_run;
    logic [1:0] error_code;
  } out_req_t;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_LEAD  = 2'd1,
    ERR_CONT  = 2'd2,
    ERR_TRUNC = 2'd3
  } err_code_t;

  // Body of a job: what sits between the optional quotes
  typedef enum logic [2:0] {
    JK_NONE,
    JK_RAW,
    JK_ESC,
    JK_U1,
    JK_U2,
    JK_ERR
  } job_kind_t;

  typedef struct packed {
    job_kind_t  kind;
    logic       open_q;
    logic       close_q;
    logic [7:0] data;    // raw byte, or escape letter
    logic [15:0] val_hi; // single \u value, or high surrogate
    logic [15:0] val_lo; // low surrogate
    err_code_t  err;
  } job_t;

  // Queue status towards the front and back
  typedef struct packed {
    logic full;
    logic nonempty;
  } q_stat_t;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_U      = 8'h75;

  localparam logic [7:0] LEAD_MIN  = 8'hC2;
  localparam logic [7:0] LEAD_3B   = 8'hE0;
  localparam logic [7:0] LEAD_4B   = 8'hF0;
  localparam logic [7:0] LEAD_TOP  = 8'hF4;
  localparam logic [7:0] LEAD_LIM  = 8'hF5;
  localparam logic [7:0] E0_SECOND = 8'hA0;
  localparam logic [7:0] F0_SECOND = 8'h90;

  // Escape letter for a control or special byte; zero when none applies
  function automatic logic [7:0] esc_char(input logic [7:0] b);
    logic [7:0] e;
    case (b)
      8'h08:     e = 8'h62; // b
      8'h0C:     e = 8'h66; // f
      8'h0A:     e = 8'h6E; // n
      8'h0D:     e = 8'h72; // r
      8'h09:     e = 8'h74; // t
      CH_QUOTE:  e = CH_QUOTE;
      CH_BSLASH: e = CH_BSLASH;
      CH_SLASH:  e = CH_SLASH;
      default:   e = 8'h00;
    endcase
    return e;
  endfunction

  // Upper-case hex digit
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] c;
    if (n < 4'd10) c = 8'h30 + {4'h0, n};
    else           c = 8'h37 + {4'h0, n};
    return c;
  endfunction

endpackage

@@ rtl/core/jse_front.sv @@
// ----------------------------------------------------------------------------
// jse_front
// Takes source bytes, tracks UTF-8 sequence state and turns each byte into
// at most one job for the serialiser.
// ----------------------------------------------------------------------------
module jse_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  jse_pkg::in_req_t req,
  output logic            push,
  output jse_pkg::job_t   job
);
  import jse_pkg::*;

  logic [20:0] code_accum;
  logic [1:0]  bytes_remaining;
  logic [7:0]  lead_value;
  logic        awaiting_second;
  logic        discarding;

  logic [20:0] code_accum_next;
  logic [1:0]  bytes_remaining_next;
  logic [7:0]  lead_value_next;
  logic        awaiting_second_next;
  logic        discarding_next;

  logic [7:0]  b;
  logic [7:0]  e;
  logic [20:0] acc_sh;
  logic [20:0] v;
  logic [1:0]  rem_d;
  logic        range_bad;
  logic        has_out;
  err_code_t   err;

  always_comb begin
    b = req.in_byte;
    e = esc_char(b);

    // A first mark abandons any open sequence
    code_accum_next      = req.first_byte ? 21'd0 : code_accum;
    bytes_remaining_next = req.first_byte ? 2'd0  : bytes_remaining;
    lead_value_next      = req.first_byte ? 8'd0  : lead_value;
    awaiting_second_next = req.first_byte ? 1'b0  : awaiting_second;
    discarding_next      = req.first_byte ? 1'b0  : discarding;

    acc_sh = {code_accum_next[14:0], b[5:0]};
    v      = acc_sh - 21'h10000;
    rem_d  = bytes_remaining_next - 2'd1;
    range_bad = awaiting_second_next &&
                ((lead_value_next == LEAD_3B  && b <  E0_SECOND) ||
                 (lead_value_next == LEAD_4B  && b <  F0_SECOND) ||
                 (lead_value_next == LEAD_TOP && b >= F0_SECOND));

    err         = ERR_NONE;
    job.kind    = JK_NONE;
    job.open_q  = req.first_byte;
    job.close_q = req.last_byte;
    job.data    = b;
    job.val_hi  = acc_sh[15:0];
    job.val_lo  = 16'h0000;
    job.err     = ERR_NONE;
    has_out     = 1'b0;

    if (!req.first_byte && discarding) begin
      if (req.last_byte) discarding_next = 1'b0;
    end else begin
      if (bytes_remaining_next == 2'd0) begin
        if (!b[7]) begin
          if (e != 8'h00) begin
            job.kind = JK_ESC;
            job.data = e;
          end else begin
            job.kind = JK_RAW;
          end
        end else if (b < LEAD_MIN || b >= LEAD_LIM) begin
          err = ERR_LEAD;
        end else begin
          lead_value_next      = b;
          awaiting_second_next = 1'b1;
          if (b < LEAD_3B) begin
            code_accum_next      = {16'd0, b[4:0]};
            bytes_remaining_next = 2'd1;
          end else if (b < LEAD_4B) begin
            code_accum_next      = {17'd0, b[3:0]};
            bytes_remaining_next = 2'd2;
          end else begin
            code_accum_next      = {18'd0, b[2:0]};
            bytes_remaining_next = 2'd3;
          end
        end
      end else begin
        if (b[7:6] != 2'b10 || range_bad) begin
          err = ERR_CONT;
        end else begin
          code_accum_next      = acc_sh;
          awaiting_second_next = 1'b0;
          bytes_remaining_next = rem_d;
          if (rem_d == 2'd0) begin
            if (acc_sh > 21'h00FFFF) begin
              job.kind   = JK_U2;
              job.val_hi = {6'b110110, v[19:10]};
              job.val_lo = {6'b110111, v[9:0]};
            end else begin
              job.kind = JK_U1;
            end
            code_accum_next = 21'd0;
            lead_value_next = 8'd0;
          end
        end
      end

      if (err == ERR_NONE && req.last_byte && bytes_remaining_next != 2'd0)
        err = ERR_TRUNC;

      if (err != ERR_NONE) begin
        code_accum_next      = 21'd0;
        bytes_remaining_next = 2'd0;
        lead_value_next      = 8'd0;
        awaiting_second_next = 1'b0;
        discarding_next      = !req.last_byte;
        job.kind             = JK_ERR;
        job.open_q           = 1'b0;
        job.close_q          = 1'b0;
        job.err              = err;
      end

      has_out = job.open_q || job.close_q || job.kind != JK_NONE;
    end

    push = accept && has_out;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      code_accum      <= 21'd0;
      bytes_remaining <= 2'd0;
      lead_value      <= 8'd0;
      awaiting_second <= 1'b0;
      discarding      <= 1'b0;
    end else if (accept) begin
      code_accum      <= code_accum_next;
      bytes_remaining <= bytes_remaining_next;
      lead_value      <= lead_value_next;
      awaiting_second <= awaiting_second_next;
      discarding      <= discarding_next;
    end
  end

endmodule

@@ rtl/core/jse_queue.sv @@
// ----------------------------------------------------------------------------
// jse_queue
// Short job queue between the classifier and the serialiser.
// ----------------------------------------------------------------------------
module jse_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  jse_pkg::job_t    push_job,
  input  logic             pop,
  output jse_pkg::job_t    head,
  output jse_pkg::q_stat_t stat
);
  import jse_pkg::*;

  job_t            slots [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_CW-1:0] count;

  assign head          = slots[rd_ptr];
  assign stat.full     = (count == Q_CW'(Q_DEPTH));
  assign stat.nonempty = (count != '0);

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/core/jse_back.sv @@
// ----------------------------------------------------------------------------
// jse_back
// Serialiser: walks the head job byte by byte into a registered output.
// ----------------------------------------------------------------------------
module jse_back (
  input  logic             clk,
  input  logic             rst,
  input  jse_pkg::job_t    head,
  input  jse_pkg::q_stat_t stat,
  output logic             pop,
  output logic             valid,
  input  logic             stall,
  output jse_pkg::out_req_t data
);
  import jse_pkg::*;

  logic [3:0]  pos;
  logic [3:0]  body_len;
  logic [3:0]  total;
  logic [3:0]  q;
  logic [3:0]  r;
  logic        sel_lo;
  logic [15:0] v;
  logic [7:0]  ch;
  logic        last_pos;
  logic        load;

  always_comb begin
    case (head.kind)
      JK_RAW:  body_len = 4'd1;
      JK_ESC:  body_len = 4'd2;
      JK_U1:   body_len = 4'd6;
      JK_U2:   body_len = 4'd12;
      JK_ERR:  body_len = 4'd1;
      default: body_len = 4'd0;
    endcase
    total = body_len + {3'd0, head.open_q} + {3'd0, head.close_q};
    q      = pos - {3'd0, head.open_q};
    sel_lo = (q >= 4'd6);
    r      = sel_lo ? q - 4'd6 : q;
    v      = sel_lo ? head.val_lo : head.val_hi;

    if (head.open_q && pos == 4'd0) begin
      ch = CH_QUOTE;
    end else if (q >= body_len) begin
      ch = CH_QUOTE;
    end else begin
      case (head.kind)
        JK_RAW: ch = head.data;
        JK_ESC: ch = (q == 4'd0) ? CH_BSLASH : head.data;
        JK_U1, JK_U2: begin
          case (r)
            4'd0:    ch = CH_BSLASH;
            4'd1:    ch = CH_U;
            4'd2:    ch = hex_char(v[15:12]);
            4'd3:    ch = hex_char(v[11:8]);
            4'd4:    ch = hex_char(v[7:4]);
            default: ch = hex_char(v[3:0]);
          endcase
        end
        default: ch = 8'h00;
      endcase
    end

    last_pos = (pos == total - 4'd1);
    load     = stat.nonempty && (!valid || !stall);
    pop      = load && last_pos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      pos   <= 4'd0;
    end else begin
      if (load) begin
        valid <= 1'b1;
        pos   <= last_pos ? 4'd0 : pos + 4'd1;
      end else if (!stall) begin
        valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data.out_byte   <= ch;
      data.end_of_run <= last_pos;
      data.error_code <= head.err;
    end
  end

endmodule

@@ rtl/core/json_string_escaper.sv @@
// Accepted bytes are queued as jobs for the back end's output register.
// One source byte per cycle while a slot is free; one output byte per cycle
//   unless stalled, so a byte of k output bytes (up to 13) holds the serialiser.
// A four-entry job queue lets the source run ahead while escapes serialise.
// Reset (rst, synchronous): clears sequence state, the queue and the output.
// ----------------------------------------------------------------------------
// json_string_escaper
// Quotes and escapes a byte stream as JSON text, with UTF-8 sequences
// validated and written as \uXXXX (surrogate pairs above the BMP).
// ----------------------------------------------------------------------------
module json_string_escaper (
  input  logic              clk,
  input  logic              rst,
  input  logic              src_valid,
  output logic              src_stall,
  input  jse_pkg::in_req_t  src_data,
  output logic              dst_valid,
  input  logic              dst_stall,
  output jse_pkg::out_req_t dst_data
);
  import jse_pkg::*;

  // Front to queue
  logic    accept;
  logic    push;
  job_t    push_job;

  // Queue to back
  job_t    head;
  q_stat_t q_stat;
  logic    pop;

  // The source is held off only when the queue has no free slot; every
  // accepted byte is classified in the same cycle.
  assign src_stall = q_stat.full;
  assign accept    = src_valid && !q_stat.full;

  jse_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .req    (src_data),
    .push   (push),
    .job    (push_job)
  );

  // Jobs that produce nothing (mid-sequence bytes, dropped bytes) never
  // enter the queue.
  jse_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  // Output register sits in the back end; it reloads while a taken byte
  // leaves, so with jobs waiting and no stall the sink sees one byte per cycle.
  jse_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .stat  (q_stat),
    .pop   (pop),
    .valid (dst_valid),
    .stall (dst_stall),
    .data  (dst_data)
  );

  // Front only writes into a free slot
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_stat.full)
    else $error("job queue overflow");

  // Back only pops a job that is present
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_stat.nonempty)
    else $error("job queue underflow");

  // An error result is always the whole reply to its byte, with a zero byte
  a_err_closes: assert property (@(posedge clk) disable iff (rst)
    dst_valid && dst_data.error_code != ERR_NONE |->
      dst_data.end_of_run && dst_data.out_byte == 8'h00)
    else $error("error result not final");

  // Output is empty straight after reset
  a_reset_out: assert property (@(posedge clk)
    rst |=> !dst_valid)
    else $error("output valid after reset");

endmodule
